// File: hdl/cct_pkg.sv
// Package for the crank cadence tracker: payload structs, status and
// controller state types, register indexes and fixed constants.
// No dependencies.
`timescale 1ns / 1ps

package cct_pkg;

   localparam int unsigned MINUTE_TICKS = 600000;
   localparam int unsigned PERIOD_STEP  = 100;
   localparam int unsigned CUTOFF_W     = 20;
   localparam int unsigned CSR_INDEX_W  = 3;
   localparam int unsigned CSR_DATA_W   = 20;

   localparam logic OP_UPDATE = 1'b0;
   localparam logic OP_PULSE  = 1'b1;

   localparam logic [1:0] HEALTH_OFF = 2'd0;
   localparam logic [1:0] HEALTH_OK  = 2'd1;

   localparam logic [CSR_INDEX_W-1:0] CSR_LOW_CUTOFF  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HIGH_CUTOFF = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COAST_EXTRA = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_POS_MAX     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CRANK_CHAN  = 3'd4;

   typedef enum logic [1:0] {
      ST_NA    = 2'd0,
      ST_OK    = 2'd1,
      ST_COAST = 2'd2,
      ST_ERR   = 2'd3
   } track_status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PREP,
      S_SEL,
      S_DIV,
      S_FIN
   } ctrl_state_type;

   typedef struct packed {
      logic        opcode;
      logic [31:0] pulse_period;
      logic [2:0]  pulse_channel;
      logic [1:0]  sensor_health;
   } req_type;

   typedef struct packed {
      logic [7:0] cadence_rpm;
      logic [1:0] track_status;
      logic [7:0] crank_position;
   } rsp_type;

endpackage

// File: hdl/cct_serdiv.sv
// Restoring divider for the crank cadence tracker, one quotient bit per cycle.
// Depends on nothing; WIDTH-bit dividend and divisor.
`timescale 1ns / 1ps

module cct_serdiv #(
   parameter int unsigned WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             busy,
   output logic             done,
   output logic [WIDTH-1:0] quotient
);

   localparam int unsigned CNT_W = $clog2(WIDTH + 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             done_ff, done_in;
   logic [WIDTH-1:0] shift_ff, shift_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] dvsr_ff, dvsr_in;
   logic [WIDTH:0]   trial;
   logic [WIDTH:0]   diff;
   logic             fits;

   assign trial = {rem_ff, shift_ff[WIDTH-1]};
   assign diff  = trial - {1'b0, dvsr_ff};
   assign fits  = trial >= {1'b0, dvsr_ff};

   always_comb begin
      count_in = count_ff;
      done_in  = 1'b0;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      dvsr_in  = dvsr_ff;
      if (start) begin
         count_in = CNT_W'(WIDTH);
         shift_in = dividend;
         rem_in   = '0;
         dvsr_in  = divisor;
      end else if (count_ff != '0) begin
         count_in = count_ff - 1'b1;
         shift_in = {shift_ff[WIDTH-2:0], fits};
         rem_in   = fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
         done_in  = (count_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      dvsr_ff  <= dvsr_in;
   end

   assign busy     = (count_ff != '0);
   assign done     = done_ff;
   assign quotient = shift_ff;

endmodule

// File: hdl/crank_cadence_tracker_core.sv
// Crank cadence tracker top level: status machine, state registers, CSRs.
// Depends on cct_pkg and cct_serdiv.
// A transfer passes S_PREP and S_FIN with no divide; a matching pulse adds S_DIV,
// and an update that recomputes cadence adds S_SEL and S_DIV (serial divider,
// one bit per cycle). S_FIN registers the response, waiting while one is held.
// Reset is synchronous: state and CSR registers to defaults, status n/a.
`timescale 1ns / 1ps

module crank_cadence_tracker_core #(
   parameter int unsigned PERIOD_BITS = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  cct_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output cct_pkg::rsp_type                   rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [cct_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [cct_pkg::CSR_DATA_W-1:0]     csr_data
);

   import cct_pkg::*;

   localparam int unsigned PB = PERIOD_BITS;

   ctrl_state_type   state_ff, state_in;
   track_status_type status_ff, status_in;
   req_type          item_ff, item_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [CUTOFF_W-1:0] low_ff, low_in;
   logic [CUTOFF_W-1:0] high_ff, high_in;
   logic [7:0]          extra_ff, extra_in;
   logic [7:0]          pmax_ff, pmax_in;
   logic [2:0]          chan_ff, chan_in;

   logic [PB-1:0] period_ff, period_in;
   logic [PB-1:0] count_ff, count_in;
   logic [7:0]    pos_ff, pos_in;
   logic [7:0]    cad_ff, cad_in;

   logic          div_start;
   logic [PB-1:0] div_dividend;
   logic [PB-1:0] div_divisor;
   logic          div_busy;
   logic          div_done;
   logic [PB-1:0] div_quot;

   logic [PB-1:0] low_ext;
   logic [PB-1:0] high_ext;
   logic [PB:0]   grown;
   logic          faulty;

   cct_serdiv #(.WIDTH(PB)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign low_ext  = PB'(low_ff);
   assign high_ext = PB'(high_ff);
   assign grown    = {1'b0, period_ff} + (PB + 1)'(PERIOD_STEP);
   assign faulty   = (item_ff.sensor_health != HEALTH_OFF) &&
                     (item_ff.sensor_health != HEALTH_OK);

   // configuration
   assign csr_ready = 1'b1;

   always_comb begin
      low_in   = low_ff;
      high_in  = high_ff;
      extra_in = extra_ff;
      pmax_in  = pmax_ff;
      chan_in  = chan_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_LOW_CUTOFF:  low_in   = csr_data;
            CSR_HIGH_CUTOFF: high_in  = csr_data;
            CSR_COAST_EXTRA: extra_in = csr_data[7:0];
            CSR_POS_MAX:     pmax_in  = csr_data[7:0];
            CSR_CRANK_CHAN:  chan_in  = csr_data[2:0];
            default: ;
         endcase
      end
   end

   // controller
   always_comb begin
      state_in     = state_ff;
      status_in    = status_ff;
      item_in      = item_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      period_in    = period_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      cad_in       = cad_ff;
      div_start    = 1'b0;
      div_dividend = PB'(MINUTE_TICKS);
      div_divisor  = period_ff;
      req_ready    = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               item_in  = req_data;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            state_in = S_FIN;
            if (item_ff.opcode == OP_PULSE) begin
               if (item_ff.pulse_channel == chan_ff) begin
                  period_in    = item_ff.pulse_period[PB-1:0];
                  pos_in       = '0;
                  div_start    = 1'b1;
                  div_dividend = item_ff.pulse_period[PB-1:0];
                  div_divisor  = PB'(PERIOD_STEP);
                  state_in     = S_DIV;
               end
            end else begin
               unique case (status_ff)
                  ST_NA: begin
                     if (count_ff != '0) status_in = ST_OK;
                     if (faulty) status_in = ST_ERR;
                  end
                  ST_OK, ST_COAST: begin
                     if (faulty) begin
                        status_in = ST_ERR;
                     end else if (|count_ff[PB-1:1]) begin
                        status_in = ST_OK;
                        count_in  = count_ff - 1'b1;
                        state_in  = S_SEL;
                     end else begin
                        if (period_ff < low_ext) begin
                           period_in = grown[PB] ? '1 : grown[PB-1:0];
                           state_in  = S_SEL;
                        end
                        status_in = ST_COAST;
                        pos_in    = pmax_ff;
                     end
                  end
                  ST_ERR: begin
                     if (item_ff.sensor_health == HEALTH_OK) status_in = ST_COAST;
                  end
                  default: ;
               endcase
            end
         end
         S_SEL: begin
            div_start = 1'b1;
            if (period_ff >= low_ext) begin
               div_divisor = low_ext;
            end else if (period_ff <= high_ext) begin
               div_divisor = high_ext;
            end else begin
               div_divisor = period_ff;
            end
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               if (item_ff.opcode == OP_PULSE) begin
                  count_in = div_quot + PB'(extra_ff);
               end else begin
                  cad_in = (|div_quot[PB-1:8]) ? 8'hFF : div_quot[7:0];
               end
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.cadence_rpm    = cad_ff;
               rsp_in.track_status   = status_ff;
               rsp_in.crank_position = pos_ff;
               rsp_valid_in          = 1'b1;
               state_in              = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         status_ff    <= ST_NA;
         rsp_valid_ff <= 1'b0;
         low_ff       <= CUTOFF_W'(60000);
         high_ff      <= CUTOFF_W'(3000);
         extra_ff     <= 8'd2;
         pmax_ff      <= 8'd36;
         chan_ff      <= 3'd0;
         period_ff    <= '0;
         count_ff     <= '0;
         pos_ff       <= '0;
         cad_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         extra_ff     <= extra_in;
         pmax_ff      <= pmax_in;
         chan_ff      <= chan_in;
         period_ff    <= period_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         cad_ff       <= cad_in;
      end
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_div_only_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV)
      else $error("divider finished outside divide state");

   a_div_running: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> div_busy || div_done)
      else $error("waiting on an idle divider");

   a_pulse_keeps_status: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PREP && item_ff.opcode == OP_PULSE) |=>
         status_ff == $past(status_ff))
      else $error("pulse transfer changed status");

   a_accept_to_prep: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == S_PREP)
      else $error("accepted transfer not processed");

endmodule

// File: tb/cct_checker.sv
// Checker for the crank cadence tracker: watches the request, response and CSR
// channels, predicts each response from its own copy of the tracker state and
// compares field by field. Depends on cct_pkg.
`timescale 1ns / 1ps

module cct_checker #(
   parameter int unsigned PERIOD_BITS = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  cct_pkg::req_type                   req_data,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  cct_pkg::rsp_type                   rsp_data,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [cct_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [cct_pkg::CSR_DATA_W-1:0]     csr_data,
   output int                                 fail_count,
   output int                                 pending,
   output int                                 checked
);

   import cct_pkg::*;

   localparam logic [31:0] PERIOD_MASK = 32'((64'd1 << PERIOD_BITS) - 64'd1);
   localparam int MISMATCH_SHOWN = 10;

   logic [CUTOFF_W-1:0] low_cut;
   logic [CUTOFF_W-1:0] high_cut;
   logic [7:0]          coast_extra;
   logic [7:0]          pos_max;
   logic [2:0]          crank_chan;

   track_status_type    status;
   logic [31:0]         last_period;
   logic [31:0]         countdown;
   logic [7:0]          position;
   logic [7:0]          cadence;

   rsp_type             expected_rsp_q[$];
   int                  n_fail;
   int                  n_checked;

   function automatic logic [7:0] rpm_for(input logic [31:0] divisor);
      logic [31:0] q;
      if (divisor == 32'd0)
         return 8'd255;
      q = MINUTE_TICKS / divisor;
      return (q > 32'd255) ? 8'd255 : q[7:0];
   endfunction

   function automatic logic [7:0] cadence_for(input logic [31:0] period);
      if (period >= 32'(low_cut))
         return rpm_for(32'(low_cut));
      if (period <= 32'(high_cut))
         return rpm_for(32'(high_cut));
      return rpm_for(period);
   endfunction

   task automatic apply_setting(input logic [CSR_INDEX_W-1:0] idx,
                                input logic [CSR_DATA_W-1:0] value);
      case (idx)
         CSR_LOW_CUTOFF:  low_cut     = value[CUTOFF_W-1:0];
         CSR_HIGH_CUTOFF: high_cut    = value[CUTOFF_W-1:0];
         CSR_COAST_EXTRA: coast_extra = value[7:0];
         CSR_POS_MAX:     pos_max     = value[7:0];
         CSR_CRANK_CHAN:  crank_chan  = value[2:0];
         default: ;
      endcase
   endtask

   function automatic rsp_type advance_tracker(input req_type item);
      logic [31:0] period;
      logic        faulty;
      rsp_type     r;
      if (item.opcode == OP_PULSE) begin
         period = item.pulse_period & PERIOD_MASK;
         if (item.pulse_channel == crank_chan) begin
            last_period = period;
            countdown   = period / PERIOD_STEP + 32'(coast_extra);
            position    = 8'd0;
         end
      end else begin
         faulty = (item.sensor_health != HEALTH_OFF) && (item.sensor_health != HEALTH_OK);
         case (status)
            ST_NA: begin
               if (countdown > 32'd0)
                  status = ST_OK;
               if (faulty)
                  status = ST_ERR;
            end
            ST_OK, ST_COAST: begin
               if (faulty) begin
                  status = ST_ERR;
               end else if (countdown > 32'd1) begin
                  cadence   = cadence_for(last_period);
                  status    = ST_OK;
                  countdown = countdown - 32'd1;
               end else begin
                  if (last_period < 32'(low_cut)) begin
                     last_period = (last_period > PERIOD_MASK - PERIOD_STEP) ?
                                   PERIOD_MASK : last_period + PERIOD_STEP;
                     cadence = cadence_for(last_period);
                  end
                  status   = ST_COAST;
                  position = pos_max;
               end
            end
            default: begin
               if (item.sensor_health == HEALTH_OK)
                  status = ST_COAST;
            end
         endcase
      end
      r.cadence_rpm    = cadence;
      r.track_status   = status;
      r.crank_position = position;
      return r;
   endfunction

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         low_cut     = CUTOFF_W'(60000);
         high_cut    = CUTOFF_W'(3000);
         coast_extra = 8'd2;
         pos_max     = 8'd36;
         crank_chan  = 3'd0;
         status      = ST_NA;
         last_period = 32'd0;
         countdown   = 32'd0;
         position    = 8'd0;
         cadence     = 8'd0;
         expected_rsp_q.delete();
         n_fail      = 0;
         n_checked   = 0;
      end else begin
         if (csr_valid && csr_ready)
            apply_setting(csr_index, csr_data);
         // pop before push: a response never belongs to the request taken on the same edge
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               n_fail++;
               if (n_fail <= MISMATCH_SHOWN)
                  $display("%0t: unexpected response cad=%0d st=%0d pos=%0d", $time,
                           rsp_data.cadence_rpm, rsp_data.track_status,
                           rsp_data.crank_position);
            end else begin
               want = expected_rsp_q.pop_front();
               n_checked++;
               if (rsp_data.cadence_rpm !== want.cadence_rpm ||
                   rsp_data.track_status !== want.track_status ||
                   rsp_data.crank_position !== want.crank_position) begin
                  n_fail++;
                  if (n_fail <= MISMATCH_SHOWN)
                     $display("%0t: mismatch on response %0d: expected cad=%0d st=%0d pos=%0d, got cad=%0d st=%0d pos=%0d",
                              $time, n_checked, want.cadence_rpm, want.track_status,
                              want.crank_position, rsp_data.cadence_rpm,
                              rsp_data.track_status, rsp_data.crank_position);
               end
            end
         end
         if (req_valid && req_ready)
            expected_rsp_q.push_back(advance_tracker(req_data));
      end
      fail_count <= n_fail;
      pending    <= expected_rsp_q.size();
      checked    <= n_checked;
   end

endmodule

// File: tb/crank_cadence_tracker_core_tb.sv
// Testbench top for crank_cadence_tracker_core: clock, reset, directed and
// random ride stimulus, CSR phases and the verdict. Depends on cct_pkg, the
// core and cct_checker, which does all prediction and comparison.
`timescale 1ns / 1ps

module crank_cadence_tracker_core_tb;

   import cct_pkg::*;

   localparam int unsigned PERIOD_BITS = 32;
   localparam int unsigned MAX_GAP     = 13;
   localparam int unsigned HOLD_CYCLES = 400;
   localparam int unsigned STALL_LIMIT = 5000;
   localparam int unsigned TAIL_CYCLES = 80;
   localparam int          PHASE_ITEMS = 200;
   localparam logic [1:0]  HEALTH_FAULT = 2'd2;
   localparam logic [1:0]  HEALTH_UNDEF = 2'd3;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;

   int                     fail_count;
   int                     pending;
   int                     checked;

   logic                   no_gaps = 1'b0;
   logic                   hold_off = 1'b0;
   int                     items_sent = 0;
   int                     settings_done = 0;
   int unsigned            stall_cycles = 0;
   logic [2:0]             crank_ch = 3'd0;
   logic [CUTOFF_W-1:0]    cur_low = CUTOFF_W'(60000);
   logic [CUTOFF_W-1:0]    cur_high = CUTOFF_W'(3000);

   crank_cadence_tracker_core #(.PERIOD_BITS(PERIOD_BITS)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   cct_checker #(.PERIOD_BITS(PERIOD_BITS)) u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .fail_count(fail_count), .pending(pending), .checked(checked)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic send_item(input req_type item);
      int unsigned gap;
      gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic drive_update(input logic [1:0] health);
      req_type item;
      item.opcode        = OP_UPDATE;
      item.pulse_period  = $urandom;
      item.pulse_channel = 3'($urandom);
      item.sensor_health = health;
      send_item(item);
   endtask

   task automatic drive_pulse(input logic [31:0] period, input logic [2:0] chan);
      req_type item;
      item.opcode        = OP_PULSE;
      item.pulse_period  = period;
      item.pulse_channel = chan;
      item.sensor_health = 2'($urandom);
      send_item(item);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // all five registers plus one write to an unmapped index, valid held across
   task automatic program_settings(input logic [CSR_DATA_W-1:0] low, input logic [CSR_DATA_W-1:0] high,
                                   input logic [CSR_DATA_W-1:0] extra,
                                   input logic [CSR_DATA_W-1:0] pmax,
                                   input logic [CSR_DATA_W-1:0] chan);
      logic [CSR_INDEX_W-1:0] idx [6];
      logic [CSR_DATA_W-1:0]  val [6];
      idx = '{CSR_LOW_CUTOFF, CSR_HIGH_CUTOFF, CSR_COAST_EXTRA, CSR_POS_MAX, CSR_CRANK_CHAN,
              CSR_INDEX_W'($urandom_range(CSR_CRANK_CHAN + 1, (1 << CSR_INDEX_W) - 1))};
      val = '{low, high, extra, pmax, chan, CSR_DATA_W'($urandom)};
      wait_for_results();
      csr_valid <= 1'b1;
      for (int i = 0; i < 6; i++) begin
         csr_index <= idx[i];
         csr_data  <= val[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      crank_ch = chan[2:0];
      cur_low  = low[CUTOFF_W-1:0];
      cur_high = high[CUTOFF_W-1:0];
      settings_done++;
   endtask

   // one crank pulse followed by a run of update ticks, with some faults and noise
   task automatic ride_segment();
      logic [31:0] period;
      int unsigned n_upd;
      int unsigned pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0, 1, 2: period = $urandom_range(0, 4000);
         3:       period = 32'(cur_high) + $urandom_range(0, 4) - 2;
         4:       period = 32'(cur_low) + $urandom_range(0, 4) - 2;
         5:       period = $urandom_range(2000, 2400);
         6, 7:    period = $urandom_range(0, 80000);
         default: period = $urandom;
      endcase
      drive_pulse(period, crank_ch);
      n_upd = $urandom_range(0, 40);
      for (int i = 0; i < n_upd; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 3)
            drive_pulse($urandom, crank_ch + 3'($urandom_range(1, 7)));
         else if (pick < 5)
            drive_update(HEALTH_FAULT);
         else if (pick < 7)
            drive_update(HEALTH_UNDEF);
         else if (pick < 13)
            drive_update(HEALTH_OFF);
         else
            drive_update(HEALTH_OK);
      end
   endtask

   task automatic ride_until(input int target);
      while (items_sent < target)
         ride_segment();
   endtask

   initial begin : receiver
      int unsigned gap;
      while (reset) @(posedge clock);
      forever begin
         if (hold_off) begin
            hold_off = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin : stimulus
      int directed_items;
      int target;
      logic [CSR_DATA_W-1:0] lo;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: leaving not-available, error recovery, cutoffs, ignored inputs
      drive_update(HEALTH_OFF);
      drive_pulse(32'd7000, 3'd5);
      drive_update(HEALTH_OK);
      drive_pulse(32'd0, 3'd0);
      drive_update(HEALTH_OFF);
      drive_update(HEALTH_OK);
      drive_update(HEALTH_OK);
      drive_update(HEALTH_FAULT);
      drive_update(HEALTH_UNDEF);
      drive_update(HEALTH_OFF);
      drive_update(HEALTH_OK);
      drive_pulse(32'hFFFF_FFFF, 3'd0);
      drive_update(HEALTH_OK);
      drive_pulse(32'd60000, 3'd0);
      drive_update(HEALTH_OK);
      drive_pulse(32'd59999, 3'd0);
      drive_update(HEALTH_OK);
      drive_pulse(32'd3000, 3'd0);
      drive_update(HEALTH_OK);
      drive_pulse(32'd3001, 3'd0);
      drive_update(HEALTH_OK);
      drive_update(HEALTH_FAULT);
      drive_update(HEALTH_OK);
      directed_items = items_sent;

      target = items_sent + PHASE_ITEMS;
      ride_until(target);

      program_settings(20'd600000, 20'd2353, 20'd0, 20'd0, 20'd7);
      target += PHASE_ITEMS;
      ride_until(target);

      no_gaps = 1'b1;
      program_settings(20'd2354, 20'd2353, 20'd255, 20'd255, 20'd3);
      target += PHASE_ITEMS;
      ride_until(target);
      no_gaps = 1'b0;

      lo = CSR_DATA_W'($urandom_range(2354, 600000));
      program_settings(lo, CSR_DATA_W'($urandom_range(2353, lo)), CSR_DATA_W'($urandom_range(0, 255)),
                       CSR_DATA_W'($urandom_range(0, 255)), CSR_DATA_W'($urandom_range(0, 7)));
      hold_off = 1'b1;
      target += PHASE_ITEMS;
      ride_until(target);

      program_settings(20'd3000, 20'd50000, 20'd1, CSR_DATA_W'($urandom_range(0, 255)), 20'd6);
      target += PHASE_ITEMS;
      ride_until(target - PHASE_ITEMS / 2);
      wait_for_results();
      ride_until(target);

      program_settings(20'd0, 20'd0, 20'd3, 20'd17, 20'd1);
      target += PHASE_ITEMS;
      ride_until(target);

      program_settings(CSR_DATA_W'($urandom), CSR_DATA_W'($urandom), CSR_DATA_W'($urandom),
                       CSR_DATA_W'($urandom), CSR_DATA_W'($urandom));
      target += PHASE_ITEMS;
      ride_until(target);

      no_gaps = 1'b1;
      program_settings(20'hFFFFF, 20'hFFFFF, CSR_DATA_W'($urandom_range(0, 255)), 20'd200, 20'd2);
      target += PHASE_ITEMS;
      ride_until(target);
      no_gaps = 1'b0;

      program_settings(20'd60000, 20'd3000, 20'd2, 20'd36, 20'd0);
      target += PHASE_ITEMS;
      ride_until(target);

      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d items (%0d directed), checked %0d responses across %0d CSR settings,",
               items_sent, directed_items, checked, settings_done);
      $display("incl. zero, saturating and overlapping cutoffs, a long response stall and a drain.");
      if (fail_count == 0 && pending == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
